// ===== rtl/core/scc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and codes for the strongly connected components core.
// ----------------------------------------------------------------------------
package scc_pkg;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_FULL     = 2'd1,
        STS_RANGE    = 2'd2,
        STS_NOT_DONE = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        ST_CLR_GRAPH,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_ADD_LINK,
        ST_RD_REQ,
        ST_RD_DATA,
        ST_RUN_CLR,
        ST_OUT_RD,
        ST_OUT_CHK,
        ST_OPEN_RD,
        ST_OPEN_WR,
        ST_WALK,
        ST_EDGE,
        ST_TGT,
        ST_CLOSE_RD,
        ST_CLOSE_WR,
        ST_POP,
        ST_PARENT,
        ST_DONE
    } step_t;

    // controller to datapath
    typedef struct packed {
        step_t step;
        logic  accept;
        logic  load_out;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        cmd_t in_cmd;
        logic add_bad;
        logic add_full;
        logic not_done;
        logic rd_range;
        logic last_null;
        logic e_null;
        logic y_out;
        logic y_visited;
        logic is_root;
        logic pop_last;
        logic wd_last;
        logic i_last;
        logic sweep_last;
        logic gsweep_last;
        logic cur_visited;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/strongly_connected_components_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// strongly_connected_components_core
// Tarjan strongly connected component labeller with an edge list store.
// ----------------------------------------------------------------------------
//  channel  signals                                         handshake
//  in       cmd, src_vertex, dst_vertex                     in_valid / in_stall
//  out      status, label, component_count,                 out_valid / out_stall
//           multi_member_count
//  cfg      cfg_wdata (vertex_count)                        cfg_we
//
//  run sweeps the vertex table, then for each unvisited vertex opens it, walks
//  its edges, pops a component at a root and returns to the parent.
//  after reset the vertex edge-list heads are swept to null, with in_stall
//  high throughout.
//  one beat is in flight at a time; a result held by out_stall does not block
//  acceptance of the next command.
// ----------------------------------------------------------------------------
module strongly_connected_components_core #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [9:0]  src_vertex,
    input  wire logic [9:0]  dst_vertex,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [9:0]       label,
    output logic [10:0]      component_count,
    output logic [9:0]       multi_member_count
);

    scc_pkg::ctl_t ctl;
    scc_pkg::sts_t sts;

    scc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .sts(sts), .ctl(ctl)
    );

    scc_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .cmd(cmd), .src_vertex(src_vertex), .dst_vertex(dst_vertex),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .label(label), .component_count(component_count),
        .multi_member_count(multi_member_count), .ctl(ctl), .sts(sts)
    );

endmodule
`default_nettype wire

// ===== rtl/core/scc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scc_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/scc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer for edge loads, label reads, graph clears and the labelling walk.
// ----------------------------------------------------------------------------
module scc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire scc_pkg::sts_t sts,
    output scc_pkg::ctl_t      ctl
);

    scc_pkg::step_t state_reg, state_next;
    logic           reply_reg, reply_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scc_pkg::ST_CLR_GRAPH;
            reply_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        reply_next   = reply_reg;
        in_stall     = (state_reg != scc_pkg::ST_IDLE);
        ctl.step     = state_reg;
        ctl.accept   = (state_reg == scc_pkg::ST_IDLE) && in_valid;
        ctl.load_out = (state_reg == scc_pkg::ST_DONE) && sts.out_free;
        unique case (state_reg)
            scc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (sts.in_cmd)
                        scc_pkg::CMD_ADD:
                            state_next = (sts.add_bad || sts.add_full) ?
                                         scc_pkg::ST_DONE : scc_pkg::ST_ADD_RD;
                        scc_pkg::CMD_RUN:
                            state_next = scc_pkg::ST_RUN_CLR;
                        scc_pkg::CMD_READ:
                            state_next = (sts.not_done || sts.rd_range) ?
                                         scc_pkg::ST_DONE : scc_pkg::ST_RD_REQ;
                        scc_pkg::CMD_CLEAR:
                        begin
                            state_next = scc_pkg::ST_CLR_GRAPH;
                            reply_next = 1'b1;
                        end
                        default: state_next = scc_pkg::ST_IDLE;
                    endcase
                end
            end
            scc_pkg::ST_CLR_GRAPH:
                if (sts.gsweep_last)
                    state_next = reply_reg ? scc_pkg::ST_DONE : scc_pkg::ST_IDLE;
            scc_pkg::ST_ADD_RD:   state_next = scc_pkg::ST_ADD_WR;
            scc_pkg::ST_ADD_WR:
                state_next = sts.last_null ? scc_pkg::ST_DONE : scc_pkg::ST_ADD_LINK;
            scc_pkg::ST_ADD_LINK: state_next = scc_pkg::ST_DONE;
            scc_pkg::ST_RD_REQ:   state_next = scc_pkg::ST_RD_DATA;
            scc_pkg::ST_RD_DATA:  state_next = scc_pkg::ST_DONE;
            scc_pkg::ST_RUN_CLR:
                if (sts.sweep_last)
                    state_next = scc_pkg::ST_OUT_RD;
            scc_pkg::ST_OUT_RD:   state_next = scc_pkg::ST_OUT_CHK;
            scc_pkg::ST_OUT_CHK:
            begin
                if (!sts.cur_visited)
                    state_next = scc_pkg::ST_OPEN_RD;
                else
                    state_next = sts.i_last ? scc_pkg::ST_DONE : scc_pkg::ST_OUT_RD;
            end
            scc_pkg::ST_OPEN_RD:  state_next = scc_pkg::ST_OPEN_WR;
            scc_pkg::ST_OPEN_WR:  state_next = scc_pkg::ST_WALK;
            scc_pkg::ST_WALK:
            begin
                if (!sts.e_null)
                    state_next = scc_pkg::ST_EDGE;
                else
                    state_next = sts.is_root ? scc_pkg::ST_CLOSE_RD : scc_pkg::ST_POP;
            end
            scc_pkg::ST_EDGE:
                state_next = sts.y_out ? scc_pkg::ST_WALK : scc_pkg::ST_TGT;
            scc_pkg::ST_TGT:
                state_next = sts.y_visited ? scc_pkg::ST_WALK : scc_pkg::ST_OPEN_RD;
            scc_pkg::ST_CLOSE_RD: state_next = scc_pkg::ST_CLOSE_WR;
            scc_pkg::ST_CLOSE_WR:
                state_next = sts.pop_last ? scc_pkg::ST_POP : scc_pkg::ST_CLOSE_RD;
            scc_pkg::ST_POP:
            begin
                if (!sts.wd_last)
                    state_next = scc_pkg::ST_PARENT;
                else
                    state_next = sts.i_last ? scc_pkg::ST_DONE : scc_pkg::ST_OUT_RD;
            end
            scc_pkg::ST_PARENT:   state_next = scc_pkg::ST_WALK;
            scc_pkg::ST_DONE:
                if (sts.out_free)
                    state_next = scc_pkg::ST_IDLE;
            default:              state_next = scc_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/scc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scc_datapath
// Edge store, vertex tables, the two stacks and the result register.
// ----------------------------------------------------------------------------
module scc_datapath #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [10:0]   cfg_wdata,
    input  wire logic [1:0]    cmd,
    input  wire logic [9:0]    src_vertex,
    input  wire logic [9:0]    dst_vertex,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [1:0]         status,
    output logic [9:0]         label,
    output logic [10:0]        component_count,
    output logic [9:0]         multi_member_count,
    input  wire scc_pkg::ctl_t ctl,
    output scc_pkg::sts_t      sts
);

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int NW   = $clog2(MAX_VERTICES + 1);
    localparam int EW   = $clog2(MAX_EDGES);
    localparam int EP   = EW + 1;
    localparam int GR_W = 2 * EP;
    localparam int VR_W = 2 + 2 * VW;
    localparam int WS_W = 3 * VW + EP;
    localparam logic [EP-1:0] NULL_EDGE = EP'(MAX_EDGES);
    localparam logic [NW-1:0] VCOUNT_RST =
        NW'((MAX_VERTICES < 1024) ? MAX_VERTICES : 1024);

    logic [NW-1:0] vcount_reg, es_unused;
    logic [EP-1:0] es_reg;
    logic          computed_reg;
    logic [NW-1:0] cf_reg, multi_reg, vc_reg, pd_reg, wd_reg, tally_reg;
    logic [VW-1:0] i_reg, sidx_reg, gidx_reg, v_reg;
    logic [VW-1:0] top_v_reg, top_low_reg, top_order_reg, xlow_reg;
    logic [EP-1:0] top_e_reg, slot_reg, last_reg;
    logic [9:0]    src_reg, dst_reg;
    logic [1:0]    res_status_reg;
    logic [VW-1:0] res_label_reg;
    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic [9:0]    label_reg;
    logic [10:0]   cc_reg;
    logic [9:0]    mm_reg;

    // ram ports
    logic            g_we, t_we, l_we, v_we, p_we, w_we;
    logic [VW-1:0]   g_waddr, g_raddr, v_waddr, v_raddr, p_waddr, p_raddr;
    logic [VW-1:0]   w_waddr, w_raddr, t_rdata, p_rdata;
    logic [EW-1:0]   t_waddr, l_waddr, e_raddr;
    logic [GR_W-1:0] g_wdata, g_rdata;
    logic [VW-1:0]   t_wdata;
    logic [EP-1:0]   l_wdata, l_rdata;
    logic [VR_W-1:0] v_wdata, v_rdata;
    logic [VW-1:0]   p_wdata;
    logic [WS_W-1:0] w_wdata, w_rdata;

    logic [10:0]   cfg_clamped;
    logic [VW-1:0] src_idx, dst_idx;
    logic          v_visited, v_assigned, take_low;
    logic [VW-1:0] v_order, v_comp;
    logic [VW-1:0] ws_v, ws_low, ws_order;
    logic [EP-1:0] ws_e;
    logic [EP-1:0] g_first, g_last;
    logic [1:0]    acc_status;

    assign es_unused = '0;
    assign src_idx = VW'(32'(src_reg));
    assign dst_idx = VW'(32'(dst_reg));
    assign {v_visited, v_assigned, v_order, v_comp} = v_rdata;
    assign {ws_v, ws_e, ws_low, ws_order} = w_rdata;
    assign {g_first, g_last} = g_rdata;
    assign take_low = !v_assigned && (v_order < top_low_reg);

    always_comb
    begin
        cfg_clamped = cfg_wdata;
        if (cfg_wdata == 11'd0)
            cfg_clamped = 11'd1;
        else if (32'(cfg_wdata) > MAX_VERTICES)
            cfg_clamped = 11'(MAX_VERTICES);
    end

    always_comb
    begin
        sts.in_cmd      = scc_pkg::cmd_t'(cmd);
        sts.add_bad     = (32'(src_vertex) >= 32'(vcount_reg)) ||
                          (32'(dst_vertex) >= 32'(vcount_reg));
        sts.add_full    = (es_reg >= NULL_EDGE);
        sts.not_done    = !computed_reg;
        sts.rd_range    = (32'(src_vertex) >= 32'(vcount_reg));
        sts.last_null   = (g_last == NULL_EDGE);
        sts.e_null      = (top_e_reg == NULL_EDGE);
        sts.y_out       = (32'(t_rdata) >= 32'(vcount_reg));
        sts.y_visited   = v_visited;
        sts.is_root     = (top_order_reg == top_low_reg);
        sts.pop_last    = (p_rdata == top_v_reg) || (pd_reg == NW'(1));
        sts.wd_last     = (wd_reg == NW'(1));
        sts.i_last      = (32'(i_reg) == 32'(vcount_reg) - 1);
        sts.sweep_last  = (32'(sidx_reg) == 32'(vcount_reg) - 1);
        sts.gsweep_last = (32'(gidx_reg) == MAX_VERTICES - 1);
        sts.cur_visited = v_visited;
        sts.out_free    = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        acc_status = scc_pkg::STS_OK;
        priority if (scc_pkg::cmd_t'(cmd) == scc_pkg::CMD_ADD)
        begin
            if (sts.add_bad)
                acc_status = scc_pkg::STS_RANGE;
            else if (sts.add_full)
                acc_status = scc_pkg::STS_FULL;
        end
        else if (scc_pkg::cmd_t'(cmd) == scc_pkg::CMD_READ)
        begin
            if (sts.not_done)
                acc_status = scc_pkg::STS_NOT_DONE;
            else if (sts.rd_range)
                acc_status = scc_pkg::STS_RANGE;
        end
    end

    // memory port steering
    always_comb
    begin
        g_we    = 1'b0;
        g_waddr = gidx_reg;
        g_wdata = {NULL_EDGE, NULL_EDGE};
        g_raddr = (ctl.step == scc_pkg::ST_ADD_RD) ? src_idx : v_reg;
        t_we    = 1'b0;
        t_waddr = es_reg[EW-1:0];
        t_wdata = dst_idx;
        l_we    = 1'b0;
        l_waddr = es_reg[EW-1:0];
        l_wdata = NULL_EDGE;
        e_raddr = top_e_reg[EW-1:0];
        v_we    = 1'b0;
        v_waddr = sidx_reg;
        v_wdata = '0;
        v_raddr = i_reg;
        p_we    = 1'b0;
        p_waddr = VW'(pd_reg);
        p_wdata = v_reg;
        p_raddr = VW'(pd_reg - NW'(1));
        w_we    = 1'b0;
        w_waddr = VW'(wd_reg - NW'(1));
        w_wdata = {top_v_reg, top_e_reg, top_low_reg, top_order_reg};
        w_raddr = VW'(wd_reg - NW'(2));
        unique case (ctl.step)
            scc_pkg::ST_CLR_GRAPH: g_we = 1'b1;
            scc_pkg::ST_ADD_WR:
            begin
                g_we    = 1'b1;
                g_waddr = src_idx;
                g_wdata = {(g_last == NULL_EDGE) ? es_reg : g_first, es_reg};
                t_we    = 1'b1;
                l_we    = 1'b1;
            end
            scc_pkg::ST_ADD_LINK:
            begin
                l_we    = 1'b1;
                l_waddr = last_reg[EW-1:0];
                l_wdata = slot_reg;
            end
            scc_pkg::ST_RD_REQ:    v_raddr = src_idx;
            scc_pkg::ST_RUN_CLR:   v_we = 1'b1;
            scc_pkg::ST_OPEN_WR:
            begin
                v_we    = 1'b1;
                v_waddr = v_reg;
                v_wdata = {1'b1, 1'b0, VW'(vc_reg), {VW{1'b0}}};
                p_we    = 1'b1;
                w_we    = (wd_reg != '0);
            end
            scc_pkg::ST_EDGE:      v_raddr = t_rdata;
            scc_pkg::ST_CLOSE_WR:
            begin
                v_we    = 1'b1;
                v_waddr = p_rdata;
                v_wdata = {1'b1, 1'b1, {VW{1'b0}}, VW'(cf_reg)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= VCOUNT_RST;
            es_reg        <= '0;
            computed_reg  <= 1'b0;
            cf_reg        <= '0;
            multi_reg     <= '0;
            vc_reg        <= '0;
            pd_reg        <= '0;
            wd_reg        <= '0;
            tally_reg     <= '0;
            i_reg         <= '0;
            sidx_reg      <= '0;
            gidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vcount_reg   <= NW'(cfg_clamped);
                computed_reg <= 1'b0;
            end
            out_valid_reg <= ctl.load_out || (out_valid_reg && out_stall);
            unique case (ctl.step)
                scc_pkg::ST_IDLE:
                begin
                    if (ctl.accept)
                    begin
                        unique case (scc_pkg::cmd_t'(cmd))
                            scc_pkg::CMD_RUN:
                            begin
                                vc_reg       <= '0;
                                cf_reg       <= '0;
                                multi_reg    <= '0;
                                pd_reg       <= '0;
                                wd_reg       <= '0;
                                sidx_reg     <= '0;
                                i_reg        <= '0;
                                computed_reg <= 1'b0;
                            end
                            scc_pkg::CMD_CLEAR:
                            begin
                                gidx_reg     <= '0;
                                es_reg       <= '0;
                                computed_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                scc_pkg::ST_CLR_GRAPH: gidx_reg <= gidx_reg + VW'(1);
                scc_pkg::ST_ADD_WR:
                begin
                    es_reg       <= es_reg + EP'(1);
                    computed_reg <= 1'b0;
                end
                scc_pkg::ST_RUN_CLR:   sidx_reg <= sidx_reg + VW'(1);
                scc_pkg::ST_OUT_CHK:
                begin
                    if (v_visited)
                    begin
                        if (sts.i_last)
                            computed_reg <= 1'b1;
                        else
                            i_reg <= i_reg + VW'(1);
                    end
                end
                scc_pkg::ST_OPEN_WR:
                begin
                    vc_reg <= vc_reg + NW'(1);
                    pd_reg <= pd_reg + NW'(1);
                    wd_reg <= wd_reg + NW'(1);
                end
                scc_pkg::ST_WALK:      tally_reg <= '0;
                scc_pkg::ST_CLOSE_WR:
                begin
                    pd_reg    <= pd_reg - NW'(1);
                    tally_reg <= tally_reg + NW'(1);
                    if (sts.pop_last)
                    begin
                        cf_reg <= cf_reg + NW'(1);
                        // component of two or more vertices
                        if (tally_reg != '0)
                            multi_reg <= multi_reg + NW'(1);
                    end
                end
                scc_pkg::ST_POP:
                begin
                    wd_reg <= wd_reg - NW'(1);
                    if (sts.wd_last)
                    begin
                        if (sts.i_last)
                            computed_reg <= 1'b1;
                        else
                            i_reg <= i_reg + VW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            status_reg <= res_status_reg;
            label_reg  <= 10'(res_label_reg);
            cc_reg     <= computed_reg ? 11'(cf_reg) : 11'd0;
            mm_reg     <= computed_reg ? 10'(multi_reg) : 10'd0;
        end
        unique case (ctl.step)
            scc_pkg::ST_IDLE:
            begin
                if (ctl.accept)
                begin
                    src_reg        <= src_vertex;
                    dst_reg        <= dst_vertex;
                    res_status_reg <= acc_status;
                    res_label_reg  <= '0;
                end
            end
            scc_pkg::ST_ADD_WR:
            begin
                slot_reg <= es_reg;
                last_reg <= g_last;
            end
            scc_pkg::ST_RD_DATA: res_label_reg <= v_comp;
            scc_pkg::ST_OUT_CHK: v_reg <= i_reg;
            scc_pkg::ST_OPEN_WR:
            begin
                top_v_reg     <= v_reg;
                top_e_reg     <= g_first;
                top_low_reg   <= VW'(vc_reg);
                top_order_reg <= VW'(vc_reg);
            end
            scc_pkg::ST_EDGE:
            begin
                top_e_reg <= l_rdata;
                v_reg     <= t_rdata;
            end
            scc_pkg::ST_TGT:
            begin
                if (v_visited && take_low)
                    top_low_reg <= v_order;
            end
            scc_pkg::ST_POP:     xlow_reg <= top_low_reg;
            scc_pkg::ST_PARENT:
            begin
                top_v_reg     <= ws_v;
                top_e_reg     <= ws_e;
                top_order_reg <= ws_order;
                top_low_reg   <= (xlow_reg < ws_low) ? xlow_reg : ws_low;
            end
            default: ;
        endcase
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign label              = label_reg;
    assign component_count    = cc_reg;
    assign multi_member_count = mm_reg ^ 10'(es_unused);

    scc_ram #(.WIDTH(GR_W), .DEPTH(MAX_VERTICES)) u_graph_ram (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata)
    );

    scc_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_target_ram (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(e_raddr), .rdata(t_rdata)
    );

    scc_ram #(.WIDTH(EP), .DEPTH(MAX_EDGES)) u_link_ram (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(e_raddr), .rdata(l_rdata)
    );

    scc_ram #(.WIDTH(VR_W), .DEPTH(MAX_VERTICES)) u_vertex_ram (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_pending_ram (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    scc_ram #(.WIDTH(WS_W), .DEPTH(MAX_VERTICES)) u_walk_ram (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

`ifndef SYNTH
    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step == scc_pkg::ST_WALK) |-> (wd_reg != '0))
        else $error("walk step with empty walk stack");

    a_pend_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step == scc_pkg::ST_CLOSE_WR) |-> (pd_reg != '0))
        else $error("component pop with empty pending stack");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pd_reg) <= MAX_VERTICES)
        else $error("pending stack overflow");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |=> out_valid_reg)
        else $error("result beat lost after load");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_strongly_connected_components_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_strongly_connected_components_core
// Self-checking bench for the Tarjan component labeller: directed table,
// a full edge store, then random graph build, run and read sequences.
// ----------------------------------------------------------------------------
module tb_strongly_connected_components_core;

    localparam int NV      = 1024;
    localparam int NE      = 4096;
    localparam int NULL_E  = NE;

    typedef struct packed {
        scc_pkg::status_t st;
        logic [9:0]       lab;
        logic [10:0]      comps;
        logic [9:0]       multi;
    } answer_t;

    typedef enum logic { ROW_BEAT, ROW_CFG } row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic          typed;
        scc_pkg::cmd_t op;
        logic [10:0]   a;
        logic [9:0]    b;
        answer_t       want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [10:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [9:0]  src_vertex;
    logic [9:0]  dst_vertex;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [9:0]  label;
    logic [10:0] component_count;
    logic [9:0]  multi_member_count;

    strongly_connected_components_core uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .cmd                (cmd),
        .src_vertex         (src_vertex),
        .dst_vertex         (dst_vertex),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .label              (label),
        .component_count    (component_count),
        .multi_member_count (multi_member_count)
    );

    // labeller mirror
    int          n_vert;
    bit [9:0]    e_tgt [NE];
    bit [12:0]   e_next [NE];
    bit [12:0]   head [NV];
    bit [12:0]   tail [NV];
    int          n_edges;
    int          order [NV];
    int          low [NV];
    int          comp [NV];
    bit          seen [NV];
    bit          placed [NV];
    int          tally [NV];
    int          pend [NV];
    int          pend_sp;
    int          walk_v [NV];
    int          walk_e [NV];
    int          walk_sp;
    int          stamp;
    int          n_comps;
    int          n_multi;
    bit          labelled;

    answer_t     pending_answers [$];
    int          errors;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    int          beats_sent;
    row_t        rows [22];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic void clear_edges();
        for (int i = 0; i < NV; i++)
        begin
            head[i] = NULL_E;
            tail[i] = NULL_E;
        end
        n_edges  = 0;
        labelled = 0;
    endfunction

    function automatic void set_vertex_count(int v);
        v = v & 11'h7ff;
        if (v == 0) v = 1;
        if (v > NV) v = NV;
        n_vert   = v;
        labelled = 0;
    endfunction

    function automatic void open_vertex(int v);
        seen[v]  = 1;
        order[v] = stamp;
        low[v]   = stamp;
        stamp++;
        pend[pend_sp++] = v;
        walk_v[walk_sp] = v;
        walk_e[walk_sp] = head[v];
        walk_sp++;
    endfunction

    function automatic void label_graph();
        int x;
        int y;
        int e;
        int p;
        for (int i = 0; i < NV; i++)
        begin
            seen[i]   = 0;
            placed[i] = 0;
            tally[i]  = 0;
        end
        pend_sp = 0;
        walk_sp = 0;
        stamp   = 0;
        n_comps = 0;
        for (int i = 0; i < n_vert; i++)
        begin
            if (seen[i]) continue;
            open_vertex(i);
            while (walk_sp > 0)
            begin
                x = walk_v[walk_sp-1];
                e = walk_e[walk_sp-1];
                if (e < NE)
                begin
                    walk_e[walk_sp-1] = e_next[e];
                    y = e_tgt[e];
                    // edges left over from a larger vertex count
                    if (y >= n_vert) continue;
                    if (!seen[y]) open_vertex(y);
                    else if (!placed[y] && order[y] < low[x]) low[x] = order[y];
                end
                else
                begin
                    walk_sp--;
                    if (order[x] == low[x])
                    begin
                        while (pend_sp > 0)
                        begin
                            pend_sp--;
                            y = pend[pend_sp];
                            comp[y]   = n_comps;
                            placed[y] = 1;
                            tally[n_comps]++;
                            if (y == x) break;
                        end
                        n_comps++;
                    end
                    if (walk_sp > 0)
                    begin
                        p = walk_v[walk_sp-1];
                        if (low[x] < low[p]) low[p] = low[x];
                    end
                end
            end
        end
        n_multi = 0;
        for (int i = 0; i < n_comps; i++)
            if (tally[i] > 1) n_multi++;
        labelled = 1;
    endfunction

    function automatic answer_t predict(scc_pkg::cmd_t op, int s, int d);
        answer_t r;
        // the ports carry ten bits only
        s = s & 'h3ff;
        d = d & 'h3ff;
        r = '0;
        r.st = scc_pkg::STS_OK;
        case (op)
            scc_pkg::CMD_ADD:
            begin
                if (s >= n_vert || d >= n_vert) r.st = scc_pkg::STS_RANGE;
                else if (n_edges >= NE) r.st = scc_pkg::STS_FULL;
                else
                begin
                    e_tgt[n_edges]  = d;
                    e_next[n_edges] = NULL_E;
                    if (tail[s] < NE) e_next[tail[s]] = n_edges;
                    else head[s] = n_edges;
                    tail[s] = n_edges;
                    n_edges++;
                    labelled = 0;
                end
            end
            scc_pkg::CMD_RUN:  label_graph();
            scc_pkg::CMD_READ:
            begin
                if (!labelled) r.st = scc_pkg::STS_NOT_DONE;
                else if (s >= n_vert) r.st = scc_pkg::STS_RANGE;
                else r.lab = comp[s];
            end
            default:  clear_edges();
        endcase
        if (labelled)
        begin
            r.comps = n_comps;
            r.multi = n_multi;
        end
        return r;
    endfunction

    // drives one beat; valid stays high into the next call unless a gap is drawn
    task automatic send_beat(scc_pkg::cmd_t op, int s, int d, logic typed = 0,
                             answer_t want = '0);
        answer_t r;
        if ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        src_vertex <= s[9:0];
        dst_vertex <= d[9:0];
        do @(posedge clk); while (in_stall);
        r = predict(op, s, d);
        pending_answers.insert(pending_answers.size(), typed ? want : r);
        beats_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_vertex_count(int v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v[10:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        set_vertex_count(v);
    endtask

    function automatic int pick_vertex();
        return $urandom_range(n_vert - 1);
    endfunction

    // graph build, run and reads with random content, some bad beats mixed in
    task automatic graph_session();
        int n_add;
        int n_rd;
        int s;
        int d;
        if ($urandom_range(99) < 30) send_beat(scc_pkg::CMD_CLEAR, $urandom, $urandom);
        n_add = $urandom_range(3 * n_vert + 2, 1);
        if (n_add > 40) n_add = $urandom_range(40, 10);
        for (int k = 0; k < n_add; k++)
        begin
            s = pick_vertex();
            d = pick_vertex();
            if (n_vert < NV && $urandom_range(99) < 8)
            begin
                if ($urandom_range(1)) s = $urandom_range(NV - 1, n_vert);
                else d = $urandom_range(NV - 1, n_vert);
            end
            send_beat(scc_pkg::CMD_ADD, s, d);
        end
        if ($urandom_range(99) < 10)
            send_beat(scc_pkg::CMD_READ, pick_vertex(), $urandom);
        send_beat(scc_pkg::CMD_RUN, $urandom, $urandom);
        n_rd = $urandom_range(8, 2);
        for (int k = 0; k < n_rd; k++)
        begin
            if ($urandom_range(99) < 10)
                send_beat(scc_pkg::CMD_READ, $urandom_range(NV - 1), $urandom);
            else
                send_beat(scc_pkg::CMD_READ, pick_vertex(), $urandom);
        end
        if ($urandom_range(99) < 15)
            send_beat(scc_pkg::cmd_t'($urandom_range(2)), $urandom, $urandom);
    endtask

    always @(posedge clk)
    begin
        answer_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                report_mismatch("unexpected result beat", 1, 0);
            end
            else
            begin
                w = pending_answers.pop_front();
                if (status != w.st) report_mismatch("status", status, w.st);
                if (label != w.lab) report_mismatch("label", label, w.lab);
                if (component_count != w.comps)
                    report_mismatch("component_count", component_count, w.comps);
                if (multi_member_count != w.multi)
                    report_mismatch("multi_member_count", multi_member_count, w.multi);
            end
        end
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    initial
    begin
        int v;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        cmd          = scc_pkg::CMD_ADD;
        src_vertex   = '0;
        dst_vertex   = '0;
        out_stall    = 1'b0;
        errors       = 0;
        beats_sent   = 0;
        snd_idle_pct = 12;
        rcv_idle_pct = 55;
        clear_edges();
        set_vertex_count(NV);
        rows = '{
            '{ROW_BEAT, 1, scc_pkg::CMD_READ,  0,    0,
              '{scc_pkg::STS_NOT_DONE, 0, 0, 0}},
            '{ROW_BEAT, 0, scc_pkg::CMD_ADD,   1023, 0,    '0},
            '{ROW_BEAT, 0, scc_pkg::CMD_ADD,   0,    1023, '0},
            '{ROW_BEAT, 0, scc_pkg::CMD_ADD,   5,    5,    '0},
            '{ROW_BEAT, 0, scc_pkg::CMD_ADD,   1023, 1023, '0},
            '{ROW_BEAT, 0, scc_pkg::CMD_RUN,   0,    0,    '0},
            '{ROW_BEAT, 0, scc_pkg::CMD_READ,  1023, 0,    '0},
            '{ROW_BEAT, 0, scc_pkg::CMD_READ,  0,    0,    '0},
            '{ROW_BEAT, 0, scc_pkg::CMD_READ,  5,    0,    '0},
            '{ROW_CFG,  0, scc_pkg::CMD_ADD,   8,    0,    '0},
            '{ROW_BEAT, 1, scc_pkg::CMD_READ,  0,    0,
              '{scc_pkg::STS_NOT_DONE, 0, 0, 0}},
            '{ROW_BEAT, 1, scc_pkg::CMD_ADD,   8,    0,
              '{scc_pkg::STS_RANGE, 0, 0, 0}},
            '{ROW_BEAT, 1, scc_pkg::CMD_ADD,   0,    1023,
              '{scc_pkg::STS_RANGE, 0, 0, 0}},
            '{ROW_BEAT, 0, scc_pkg::CMD_RUN,   0,    0,    '0},
            '{ROW_BEAT, 0, scc_pkg::CMD_READ,  8,    0,    '0},
            '{ROW_BEAT, 0, scc_pkg::CMD_READ,  7,    0,    '0},
            '{ROW_CFG,  0, scc_pkg::CMD_ADD,   0,    0,    '0},
            '{ROW_BEAT, 0, scc_pkg::CMD_RUN,   0,    0,    '0},
            '{ROW_BEAT, 0, scc_pkg::CMD_READ,  1,    0,    '0},
            '{ROW_CFG,  0, scc_pkg::CMD_ADD,   2047, 0,    '0},
            '{ROW_BEAT, 1, scc_pkg::CMD_CLEAR, 0,    0,
              '{scc_pkg::STS_OK, 0, 0, 0}},
            '{ROW_BEAT, 1, scc_pkg::CMD_READ,  3,    0,
              '{scc_pkg::STS_NOT_DONE, 0, 0, 0}}
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG) write_vertex_count(rows[i].a);
            else send_beat(rows[i].op, rows[i].a, rows[i].b, rows[i].typed, rows[i].want);
        end

        // fill the edge store, then one add too many and a bad one behind it
        write_vertex_count(4);
        for (int k = 0; k < NE; k++)
            send_beat(scc_pkg::CMD_ADD, $urandom_range(3), $urandom_range(3));
        send_beat(scc_pkg::CMD_ADD, 1, 2, 1, '{scc_pkg::STS_FULL, 0, 0, 0});
        send_beat(scc_pkg::CMD_ADD, 4, 2, 1, '{scc_pkg::STS_RANGE, 0, 0, 0});
        send_beat(scc_pkg::CMD_RUN, 0, 0);
        send_beat(scc_pkg::CMD_READ, 3, 0);
        send_beat(scc_pkg::CMD_CLEAR, 0, 0);

        for (int ph = 0; ph < 3; ph++)
        begin
            snd_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 55 : 0;
            rcv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 12 : 0;
            beats_sent = 0;
            while (beats_sent < 150)
            begin
                case ($urandom_range(9))
                    0:       v = $urandom_range(1) ? 0 : 1;
                    1:       v = $urandom_range(1) ? NV : $urandom_range(2047, NV + 1);
                    default: v = $urandom_range(16, 2);
                endcase
                write_vertex_count(v);
                repeat ($urandom_range(4, 2)) graph_session();
            end
        end

        drain();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
